### rtl/core/sccc_pkg.sv
package sccc_pkg;

    localparam int DUTY_W   = 16;              // duty width
    localparam int SUM_W    = DUTY_W + 2;      // L+M+H, 3L, L+2M
    localparam int PROD_W   = SUM_W + DUTY_W;  // numerator product
    localparam int NUM_W    = PROD_W + 1;      // 2*N + S
    localparam int DEN_W    = SUM_W + 1;       // 2*S
    localparam int QBITS    = DUTY_W;          // quotient bits, one per step
    localparam int LANE_STG = QBITS + 2;       // multiply, init, divide steps
    localparam int NCH      = 3;

    typedef logic [1:0] t_chan;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
    } t_duty_in;

    typedef struct packed {
        logic [DUTY_W-1:0] fixed_a;
        logic [DUTY_W-1:0] fixed_b;
        logic [DUTY_W-1:0] fixed_c;
    } t_duty_out;

    // Side band carried beside the divider lanes.
    typedef struct packed {
        t_chan             idx_l;
        t_chan             idx_m;
        t_chan             idx_h;
        logic [DUTY_W-1:0] high;
        logic              zero;
    } t_side;

endpackage

### rtl/core/sccc_chan_if.sv
interface sccc_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/sccc_lane.sv
// One correction lane: product, then restoring divide with round half up.
module sccc_lane (
    input  logic                                i_clk,
    input  logic [sccc_pkg::LANE_STG-1:0]       i_adv,
    input  logic [sccc_pkg::SUM_W-1:0]          i_mul_a,
    input  logic [sccc_pkg::DUTY_W-1:0]         i_mul_b,
    input  logic [sccc_pkg::SUM_W-1:0]          i_sum,
    output logic [sccc_pkg::DUTY_W-1:0]         o_quot
);
    localparam int QB = sccc_pkg::QBITS;
    localparam int DW = sccc_pkg::DEN_W;

    logic [sccc_pkg::PROD_W-1:0] r_prod;
    logic [sccc_pkg::SUM_W-1:0]  r_sum;

    logic [DW-1:0] r_rem  [0:QB];
    logic [QB-1:0] r_word [0:QB];
    logic [DW-1:0] r_den  [0:QB];
    logic          r_ovf  [0:QB];

    logic [sccc_pkg::NUM_W-1:0] n_num;
    logic [DW-1:0]              n_den;

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_prod <= {{sccc_pkg::DUTY_W{1'b0}}, i_mul_a} *
                      {{sccc_pkg::SUM_W{1'b0}}, i_mul_b};
            r_sum  <= i_sum;
        end
    end

    // numerator 2N+S over 2S gives floor(N/S + 1/2)
    always_comb begin
        n_num = {r_prod, 1'b0} + {{(sccc_pkg::NUM_W - sccc_pkg::SUM_W){1'b0}}, r_sum};
        n_den = {r_sum, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r_rem[0]  <= n_num[sccc_pkg::NUM_W-1:QB];
            r_word[0] <= n_num[QB-1:0];
            r_den[0]  <= n_den;
            r_ovf[0]  <= (n_num[sccc_pkg::NUM_W-1:QB] >= n_den);
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [DW:0]   w_t;
        logic [DW:0]   w_diff;
        logic          w_ge;
        logic [DW-1:0] n_rem;

        always_comb begin
            w_t    = {r_rem[j], r_word[j][QB-1]};
            w_ge   = (w_t >= {1'b0, r_den[j]});
            w_diff = w_t - {1'b0, r_den[j]};
            n_rem  = w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[j+2]) begin
                r_rem[j+1]  <= n_rem;
                r_word[j+1] <= {r_word[j][QB-2:0], w_ge};
                r_den[j+1]  <= r_den[j];
                r_ovf[j+1]  <= r_ovf[j];
            end
        end
    end

    assign o_quot = r_ovf[QB] ? '1 : r_word[QB];

endmodule

### rtl/core/three_channel_shared_current_correct.sv
// Shared-current duty correction for three LED channels.
//
// i_in  (sink):   one transaction carries duty_a/b/c, the requested duties.
// o_out (source): one transaction carries fixed_a/b/c, the corrected duties,
//                 in the same channel positions, one result per input.
// Duties are ranked low/mid/high; high passes through, low becomes
// round(3*L*H/S) and mid round((L+2*M)*H/S), S = L+M+H; all zero if S = 0.
//
// Throughput: one transaction per cycle while the receiver is not stalling.
// Two divider lanes (low, mid) run side by side, each a 16-step restoring
// divider with one quotient bit per pipeline stage; the lanes' results are
// merged into the output register. A result passes through the rank,
// multiply, divider setup, 16 divide-step and merge registers in turn.
//
// Reset (synchronous, active low) empties the pipeline; no result is
// pending afterwards. When the receiver stalls, the pipeline compacts:
// stages ahead of an empty slot keep moving, so i_in.ready stays high
// until every stage holds a transaction.
module three_channel_shared_current_correct (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sccc_chan_if.sink   i_in,
    sccc_chan_if.source o_out
);
    localparam int DW = sccc_pkg::DUTY_W;
    localparam int SW = sccc_pkg::SUM_W;
    localparam int NP = sccc_pkg::LANE_STG + 1;   // rank stage + lane stages

    // ---------------- pipeline control ----------------
    logic [NP-1:0] r_v;
    logic [NP:0]   w_rdy;      // stage k may load
    logic          r_out_valid;

    always_comb begin
        w_rdy[NP] = !r_out_valid || o_out.ready;
        for (int k = NP - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign i_in.ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NP; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_rdy[NP]) begin
                r_out_valid <= r_v[NP-1];
            end
        end
    end

    // ---------------- rank stage ----------------
    logic [DW-1:0]       w_v0, w_v1, w_v2, w_tv;
    sccc_pkg::t_chan     w_i0, w_i1, w_i2, w_ti;
    logic [SW-1:0]       w_sum;

    // three compare-swaps, ascending
    always_comb begin
        w_tv = '0;
        w_ti = '0;
        w_v0 = i_in.payload.duty_a;
        w_v1 = i_in.payload.duty_b;
        w_v2 = i_in.payload.duty_c;
        w_i0 = sccc_pkg::t_chan'(0);
        w_i1 = sccc_pkg::t_chan'(1);
        w_i2 = sccc_pkg::t_chan'(2);
        if (w_v0 > w_v1) begin
            w_tv = w_v0; w_v0 = w_v1; w_v1 = w_tv;
            w_ti = w_i0; w_i0 = w_i1; w_i1 = w_ti;
        end
        if (w_v1 > w_v2) begin
            w_tv = w_v1; w_v1 = w_v2; w_v2 = w_tv;
            w_ti = w_i1; w_i1 = w_i2; w_i2 = w_ti;
        end
        if (w_v0 > w_v1) begin
            w_tv = w_v0; w_v0 = w_v1; w_v1 = w_tv;
            w_ti = w_i0; w_i0 = w_i1; w_i1 = w_ti;
        end
        w_sum = SW'(w_v0) + SW'(w_v1) + SW'(w_v2);
    end

    logic [DW-1:0]   r_low, r_mid;
    logic [SW-1:0]   r_sum;
    sccc_pkg::t_side r_side [0:NP-1];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_low          <= w_v0;
            r_mid          <= w_v1;
            r_sum          <= w_sum;
            r_side[0].idx_l <= w_i0;
            r_side[0].idx_m <= w_i1;
            r_side[0].idx_h <= w_i2;
            r_side[0].high  <= w_v2;
            r_side[0].zero  <= (w_sum == '0);
        end
        for (int k = 1; k < NP; k++) begin
            if (w_rdy[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- divider lanes ----------------
    logic [SW-1:0] w_a_low, w_a_mid;
    logic [DW-1:0] w_q_low, w_q_mid;

    assign w_a_low = {r_low, 1'b0} + SW'(r_low);          // 3L
    assign w_a_mid = SW'(r_low) + {1'b0, r_mid, 1'b0};    // L + 2M

    sccc_lane u_lane_low (
        .i_clk   (i_clk),
        .i_adv   (w_rdy[NP-1:1]),
        .i_mul_a (w_a_low),
        .i_mul_b (r_side[0].high),
        .i_sum   (r_sum),
        .o_quot  (w_q_low)
    );

    sccc_lane u_lane_mid (
        .i_clk   (i_clk),
        .i_adv   (w_rdy[NP-1:1]),
        .i_mul_a (w_a_mid),
        .i_mul_b (r_side[0].high),
        .i_sum   (r_sum),
        .o_quot  (w_q_mid)
    );

    // ---------------- merge back to channel positions ----------------
    logic [DW-1:0]       w_res [0:sccc_pkg::NCH-1];
    sccc_pkg::t_duty_out r_out;

    always_comb begin
        for (int ch = 0; ch < sccc_pkg::NCH; ch++) begin
            if (r_side[NP-1].zero) begin
                w_res[ch] = '0;
            end else if (r_side[NP-1].idx_h == sccc_pkg::t_chan'(ch)) begin
                w_res[ch] = r_side[NP-1].high;
            end else if (r_side[NP-1].idx_m == sccc_pkg::t_chan'(ch)) begin
                w_res[ch] = w_q_mid;
            end else begin
                w_res[ch] = w_q_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NP]) begin
            r_out.fixed_a <= w_res[0];
            r_out.fixed_b <= w_res[1];
            r_out.fixed_c <= w_res[2];
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule
